### rtl/bpa_pkg.sv
// Buddy page allocator package: page entry layout, link and status codes.
// Depends on nothing; imported by buddy_page_allocator_top.
package bpa_pkg;

    typedef logic [16:0] idx_t;

    localparam idx_t LINK_NIL  = 17'h1FFFF;
    localparam idx_t COUNT_MAX = 17'h1FFFF;
    localparam idx_t CFG_RESET = 17'h10000;

    // One page entry of the link store
    typedef struct packed {
        idx_t       nxt;
        idx_t       prv;
        logic [3:0] ord;
        logic       free;
    } entry_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_BLOCK = 3'd1,
        ST_RANGE    = 3'd2,
        ST_DOUBLE   = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_ALLOC     = 2'd0,
        MODE_ALLOC_LOW = 2'd1,
        MODE_FREE      = 2'd2,
        MODE_ADD       = 2'd3
    } mode_t;

    localparam logic CFG_PAGE_COUNT = 1'b0;
    localparam logic CFG_LOW_LIMIT  = 1'b1;

endpackage

### rtl/buddy_page_allocator_top.sv
// Buddy page allocator: free lists in a single-port page entry memory,
// driven by one sequencer. Depends on bpa_pkg.

// After reset the block sweeps the page entry memory once, one entry per
// cycle, and accepts no item until done; configuration writes are taken
// throughout. Each item then runs on one sequencer around the single-port
// page entry memory, where an update of an existing entry is a read
// followed by a write. Allocate scans the orders upward from the wanted one,
// unlinks the block found and splits it down; the below-limit variant also
// walks each list. Free checks the block, merges it with free buddies and
// pushes the result. Add range carves one aligned block per pass. The result
// is held in an output register, and the next item is taken while it waits.
module buddy_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 65536,
    parameter int TOP_ORDER = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [3:0]  block_order,
    input  logic [15:0] page_index,
    input  logic [16:0] end_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] block_index,
    output logic [16:0] avail_pages,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int   DEPTH    = (NUM_PAGES < 65536) ? NUM_PAGES : 65536;
    localparam int   AW       = $clog2(DEPTH);
    localparam int   OW       = $clog2(TOP_ORDER + 1);
    localparam int   SW       = $clog2(NUM_PAGES + 1);
    localparam int   NP_CLIP  = (NUM_PAGES > 131071) ? 131071 : NUM_PAGES;
    localparam idx_t NP17     = idx_t'(NP_CLIP);
    localparam logic [4:0] TOP5 = 5'(TOP_ORDER);
    localparam logic [SW-1:0] STEP_MAX = SW'(NUM_PAGES);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    typedef enum logic [27:0] {
        S_CLR     = 28'h0000001,
        S_IDLE    = 28'h0000002,
        S_A_SCAN  = 28'h0000004,
        S_A_WALK  = 28'h0000008,
        S_A_WLD   = 28'h0000010,
        S_SPLIT   = 28'h0000020,
        S_FIN_RD  = 28'h0000040,
        S_FIN_WR  = 28'h0000080,
        S_F_RD    = 28'h0000100,
        S_F_CHK   = 28'h0000200,
        S_M_TEST  = 28'h0000400,
        S_M_CHK   = 28'h0000800,
        S_M_NEXT  = 28'h0001000,
        S_AD_LOOP = 28'h0002000,
        S_AD_NEXT = 28'h0004000,
        S_PU_I    = 28'h0008000,
        S_PU_H_RD = 28'h0010000,
        S_PU_H_WR = 28'h0020000,
        S_PU_END  = 28'h0040000,
        S_RM_I_RD = 28'h0080000,
        S_RM_LD   = 28'h0100000,
        S_RM_N_RD = 28'h0200000,
        S_RM_N_WR = 28'h0400000,
        S_RM_P_RD = 28'h0800000,
        S_RM_P_WR = 28'h1000000,
        S_RM_C_RD = 28'h2000000,
        S_RM_C_WR = 28'h4000000,
        S_DONE    = 28'h8000000
    } state_t;

    function automatic logic in_store(idx_t i);
        return i < NP17;
    endfunction

    // Index of the lowest set bit
    function automatic logic [4:0] low_one(idx_t v);
        logic [4:0] r;
        r = 5'd0;
        for (int k = 16; k >= 0; k--) begin
            if (v[k]) r = 5'(k);
        end
        return r;
    endfunction

    // Index of the highest set bit
    function automatic logic [4:0] high_one(idx_t v);
        logic [4:0] r;
        r = 5'd0;
        for (int k = 0; k <= 16; k++) begin
            if (v[k]) r = 5'(k);
        end
        return r;
    endfunction

    state_t        state_reg;
    state_t        ret_reg;
    logic [AW-1:0] clr_reg;
    mode_t         mode_reg;
    logic [3:0]    ord_reg;
    idx_t          cur_reg;
    idx_t          end_reg;
    idx_t          blk_reg;
    logic [3:0]    from_reg;
    logic [4:0]    f_reg;
    logic [SW-1:0] steps_reg;
    status_t       status_reg;
    logic [3:0]    push_o_reg;
    idx_t          push_i_reg;
    idx_t          push_h_reg;
    logic [3:0]    rm_o_reg;
    idx_t          rm_i_reg;
    idx_t          n_reg;
    idx_t          p_reg;
    idx_t          count_reg;
    idx_t          page_count_reg;
    idx_t          low_limit_reg;
    idx_t          head_reg [TOP_ORDER+1];
    logic          out_valid_reg;
    logic [2:0]    status_out_reg;
    logic [15:0]   block_out_reg;
    idx_t          free_out_reg;

    entry_t        mem [DEPTH];
    entry_t        mem_rdata;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_addr;
    logic          mem_we;

    logic [OW-1:0] head_sel;
    idx_t          head_rd;
    idx_t          lim;
    idx_t          bud;
    idx_t          rest;
    logic [4:0]    al5;
    logic [4:0]    sp5;
    logic [4:0]    o5;
    logic [3:0]    add_ord;
    logic [3:0]    split_ord;
    logic          fits;
    logic [17:0]   sat_sum;
    idx_t          count_add;
    idx_t          rm_sz;

    // Effective page bound and per-step arithmetic
    always_comb
    begin
        lim       = (page_count_reg < NP17) ? page_count_reg : NP17;
        bud       = cur_reg ^ (idx_t'(1) << from_reg);
        rest      = end_reg - cur_reg;
        al5       = (cur_reg == '0) ? TOP5 : low_one(cur_reg);
        sp5       = high_one(rest);
        o5        = (al5 < sp5) ? al5 : sp5;
        if (o5 > TOP5) o5 = TOP5;
        add_ord   = o5[3:0];
        split_ord = from_reg - 4'd1;
        fits      = ({1'b0, cur_reg} + (18'd1 << f_reg[3:0])) <= {1'b0, low_limit_reg};
        sat_sum   = {1'b0, count_reg} + (18'd1 << push_o_reg);
        count_add = sat_sum[17] ? COUNT_MAX : sat_sum[16:0];
        rm_sz     = idx_t'(1) << rm_o_reg;
        head_sel  = (state_reg == S_A_SCAN) ? f_reg[OW-1:0] : push_o_reg[OW-1:0];
        head_rd   = head_reg[head_sel];
    end

    // Address and write data of the page entry memory
    always_comb
    begin
        mem_addr  = '0;
        mem_we    = 1'b0;
        mem_wdata = mem_rdata;
        unique case (state_reg)
            S_CLR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                mem_wdata = '{nxt: LINK_NIL, prv: LINK_NIL, ord: 4'd0, free: 1'b0};
            end
            S_PU_I:
            begin
                mem_addr  = push_i_reg[AW-1:0];
                mem_we    = in_store(push_i_reg);
                mem_wdata = '{nxt: head_rd, prv: LINK_NIL, ord: push_o_reg, free: 1'b1};
            end
            S_PU_H_RD: mem_addr = push_h_reg[AW-1:0];
            S_PU_H_WR:
            begin
                mem_addr      = push_h_reg[AW-1:0];
                mem_we        = 1'b1;
                mem_wdata.prv = push_i_reg;
            end
            S_RM_I_RD, S_RM_C_RD: mem_addr = rm_i_reg[AW-1:0];
            S_RM_C_WR:
            begin
                mem_addr       = rm_i_reg[AW-1:0];
                mem_we         = 1'b1;
                mem_wdata.nxt  = LINK_NIL;
                mem_wdata.prv  = LINK_NIL;
                mem_wdata.free = 1'b0;
            end
            S_RM_N_RD: mem_addr = n_reg[AW-1:0];
            S_RM_N_WR:
            begin
                mem_addr      = n_reg[AW-1:0];
                mem_we        = 1'b1;
                mem_wdata.prv = p_reg;
            end
            S_RM_P_RD: mem_addr = p_reg[AW-1:0];
            S_RM_P_WR:
            begin
                mem_addr      = p_reg[AW-1:0];
                mem_we        = 1'b1;
                mem_wdata.nxt = n_reg;
            end
            S_A_WALK, S_F_RD: mem_addr = cur_reg[AW-1:0];
            S_FIN_RD: mem_addr = blk_reg[AW-1:0];
            S_FIN_WR:
            begin
                mem_addr       = blk_reg[AW-1:0];
                mem_we         = 1'b1;
                mem_wdata.ord  = ord_reg;
                mem_wdata.free = 1'b0;
            end
            S_M_TEST: mem_addr = bud[AW-1:0];
            default: mem_addr = '0;
        endcase
    end

    // Page entry memory with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        mem_rdata <= mem[mem_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            ret_reg        <= S_DONE;
            clr_reg        <= '0;
            mode_reg       <= MODE_ALLOC;
            ord_reg        <= '0;
            cur_reg        <= '0;
            end_reg        <= '0;
            blk_reg        <= '0;
            from_reg       <= '0;
            f_reg          <= '0;
            steps_reg      <= '0;
            status_reg     <= ST_OK;
            push_o_reg     <= '0;
            push_i_reg     <= '0;
            push_h_reg     <= '0;
            rm_o_reg       <= '0;
            rm_i_reg       <= '0;
            n_reg          <= '0;
            p_reg          <= '0;
            count_reg      <= '0;
            page_count_reg <= CFG_RESET;
            low_limit_reg  <= CFG_RESET;
            out_valid_reg  <= 1'b0;
            status_out_reg <= '0;
            block_out_reg  <= '0;
            free_out_reg   <= '0;
            for (int k = 0; k <= TOP_ORDER; k++) head_reg[k] <= LINK_NIL;
        end
        else
        begin
            // Take configuration writes
            if (cfg_valid)
            begin
                if (cfg_index == CFG_PAGE_COUNT) page_count_reg <= cfg_data;
                else                             low_limit_reg  <= cfg_data;
            end

            // Drop the result once transferred, unless a new one replaces it
            if (out_valid_reg && !out_stall && state_reg != S_DONE) out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_LAST) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg   <= mode_t'(mode);
                        ord_reg    <= block_order;
                        f_reg      <= {1'b0, block_order};
                        cur_reg    <= {1'b0, page_index};
                        end_reg    <= (end_index < lim) ? end_index : lim;
                        blk_reg    <= '0;
                        status_reg <= ST_OK;
                        unique case (mode_t'(mode))
                            MODE_ALLOC, MODE_ALLOC_LOW:
                            begin
                                status_reg <= ST_NO_BLOCK;
                                state_reg  <= S_A_SCAN;
                            end
                            MODE_FREE: state_reg <= S_F_RD;
                            MODE_ADD:  state_reg <= S_AD_LOOP;
                            default:   state_reg <= S_IDLE;
                        endcase
                    end
                end
                // Allocate: scan orders, walk a list in the low-limit variant
                S_A_SCAN:
                begin
                    if (f_reg > TOP5) state_reg <= S_DONE;
                    else
                    begin
                        cur_reg   <= head_rd;
                        steps_reg <= '0;
                        state_reg <= S_A_WALK;
                    end
                end
                S_A_WALK:
                begin
                    if (cur_reg == LINK_NIL || steps_reg == STEP_MAX)
                    begin
                        f_reg     <= f_reg + 5'd1;
                        state_reg <= S_A_SCAN;
                    end
                    else if (mode_reg == MODE_ALLOC || fits)
                    begin
                        blk_reg   <= cur_reg;
                        from_reg  <= f_reg[3:0];
                        rm_o_reg  <= f_reg[3:0];
                        rm_i_reg  <= cur_reg;
                        ret_reg   <= S_SPLIT;
                        state_reg <= S_RM_I_RD;
                    end
                    else if (in_store(cur_reg)) state_reg <= S_A_WLD;
                    else
                    begin
                        cur_reg   <= LINK_NIL;
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                S_A_WLD:
                begin
                    cur_reg   <= mem_rdata.nxt;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_A_WALK;
                end
                // Split: push the right half one order down
                S_SPLIT:
                begin
                    if (from_reg > ord_reg)
                    begin
                        from_reg   <= split_ord;
                        push_o_reg <= split_ord;
                        push_i_reg <= blk_reg + (idx_t'(1) << split_ord);
                        ret_reg    <= S_SPLIT;
                        state_reg  <= S_PU_I;
                    end
                    else state_reg <= S_FIN_RD;
                end
                S_FIN_RD:
                begin
                    status_reg <= ST_OK;
                    state_reg  <= in_store(blk_reg) ? S_FIN_WR : S_DONE;
                end
                S_FIN_WR: state_reg <= S_DONE;
                // Free: check, then merge with free buddies
                S_F_RD:
                begin
                    if (cur_reg >= lim)
                    begin
                        status_reg <= ST_RANGE;
                        state_reg  <= S_DONE;
                    end
                    else state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    if (mem_rdata.free)
                    begin
                        status_reg <= ST_DOUBLE;
                        state_reg  <= S_DONE;
                    end
                    else if (mem_rdata.ord != ord_reg)
                    begin
                        status_reg <= ST_MISMATCH;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        from_reg  <= ord_reg;
                        state_reg <= S_M_TEST;
                    end
                end
                S_M_TEST:
                begin
                    if ({1'b0, from_reg} >= TOP5 || bud >= lim)
                    begin
                        push_o_reg <= from_reg;
                        push_i_reg <= cur_reg;
                        ret_reg    <= S_DONE;
                        state_reg  <= S_PU_I;
                    end
                    else
                    begin
                        rm_i_reg  <= bud;
                        state_reg <= S_M_CHK;
                    end
                end
                S_M_CHK:
                begin
                    if (!mem_rdata.free || mem_rdata.ord != from_reg)
                    begin
                        push_o_reg <= from_reg;
                        push_i_reg <= cur_reg;
                        ret_reg    <= S_DONE;
                        state_reg  <= S_PU_I;
                    end
                    else
                    begin
                        rm_o_reg  <= from_reg;
                        ret_reg   <= S_M_NEXT;
                        state_reg <= S_RM_I_RD;
                    end
                end
                S_M_NEXT:
                begin
                    cur_reg   <= cur_reg & ~(idx_t'(1) << from_reg);
                    from_reg  <= from_reg + 4'd1;
                    state_reg <= S_M_TEST;
                end
                // Add range: carve the largest aligned block each pass
                S_AD_LOOP:
                begin
                    if (cur_reg >= end_reg) state_reg <= S_DONE;
                    else
                    begin
                        push_o_reg <= add_ord;
                        push_i_reg <= cur_reg;
                        ret_reg    <= S_AD_NEXT;
                        state_reg  <= S_PU_I;
                    end
                end
                S_AD_NEXT:
                begin
                    cur_reg   <= cur_reg + (idx_t'(1) << push_o_reg);
                    state_reg <= S_AD_LOOP;
                end
                // Push onto the head of a free list
                S_PU_I:
                begin
                    if (in_store(push_i_reg))
                    begin
                        push_h_reg <= head_rd;
                        state_reg  <= S_PU_H_RD;
                    end
                    else state_reg <= ret_reg;
                end
                S_PU_H_RD: state_reg <= in_store(push_h_reg) ? S_PU_H_WR : S_PU_END;
                S_PU_H_WR: state_reg <= S_PU_END;
                S_PU_END:
                begin
                    head_reg[push_o_reg[OW-1:0]] <= push_i_reg;
                    count_reg <= count_add;
                    state_reg <= ret_reg;
                end
                // Unlink an entry from a free list
                S_RM_I_RD: state_reg <= in_store(rm_i_reg) ? S_RM_LD : ret_reg;
                S_RM_LD:
                begin
                    n_reg     <= mem_rdata.nxt;
                    p_reg     <= mem_rdata.prv;
                    state_reg <= S_RM_N_RD;
                end
                S_RM_N_RD: state_reg <= in_store(n_reg) ? S_RM_N_WR : S_RM_P_RD;
                S_RM_N_WR: state_reg <= S_RM_P_RD;
                S_RM_P_RD:
                begin
                    if (in_store(p_reg)) state_reg <= S_RM_P_WR;
                    else
                    begin
                        if (p_reg == LINK_NIL) head_reg[rm_o_reg[OW-1:0]] <= n_reg;
                        state_reg <= S_RM_C_RD;
                    end
                end
                S_RM_P_WR: state_reg <= S_RM_C_RD;
                S_RM_C_RD: state_reg <= S_RM_C_WR;
                S_RM_C_WR:
                begin
                    if (count_reg >= rm_sz) count_reg <= count_reg - rm_sz;
                    state_reg <= ret_reg;
                end
                // Hand the result to the output register
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        status_out_reg <= status_reg;
                        block_out_reg  <= (status_reg == ST_OK) ? blk_reg[15:0] : 16'd0;
                        free_out_reg   <= count_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign status      = status_out_reg;
    assign block_index = block_out_reg;
    assign avail_pages = free_out_reg;

endmodule

### tb/buddy_page_allocator_top_test.sv
// Self-checking testbench for buddy_page_allocator_top: random and directed allocate,
// free and add-range requests, checked against a behavioral free-list model.
// Depends on bpa_pkg and buddy_page_allocator_top.
module buddy_page_allocator_top_test;
    import bpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPAGES    = 65536;
    localparam int TOP_ORD   = 10;
    localparam int HALF_CLK  = 6;
    localparam int FRESH_CAP = 64512;

    typedef struct {
        mode_t       mode;
        logic [3:0]  ord;
        logic [15:0] idx;
        logic [16:0] end_idx;
        status_t     st;
        logic [15:0] blk;
        logic [16:0] fp;
    } page_req_t;

    typedef struct {
        int unsigned idx;
        int unsigned ord;
    } held_blk_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = '0;
    logic [3:0]  block_order = '0;
    logic [15:0] page_index = '0;
    logic [16:0] end_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [15:0] block_index;
    logic [16:0] avail_pages;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [16:0] cfg_data = '0;

    buddy_page_allocator_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .block_order (block_order),
        .page_index  (page_index),
        .end_index   (end_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .block_index (block_index),
        .avail_pages (avail_pages),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Free-list model state
    idx_t        page_nxt [NPAGES];
    idx_t        page_prv [NPAGES];
    logic [3:0]  page_ord [NPAGES];
    logic        page_is_free [NPAGES];
    idx_t        order_head [TOP_ORD + 1];
    int unsigned free_total;
    int unsigned cfg_pages;
    int unsigned cfg_low;

    page_req_t   pending_reqs [$];
    page_req_t   owed_results [$];
    page_req_t   in_flight;
    held_blk_t   held_blks [$];
    int unsigned fresh_mark;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_status [5];

    // Clock
    always
    begin
        #HALF_CLK clk = 1'b1;
        #HALF_CLK clk = 1'b0;
    end

    function automatic int unsigned page_bound();
        return (cfg_pages < NPAGES) ? cfg_pages : NPAGES;
    endfunction

    function automatic void push_free(int unsigned o, int unsigned i);
        idx_t h;
        if (i >= NPAGES || o > TOP_ORD) return;
        h = order_head[o];
        page_nxt[i] = h;
        page_prv[i] = LINK_NIL;
        if (h != LINK_NIL && h < NPAGES) page_prv[h] = idx_t'(i);
        order_head[o] = idx_t'(i);
        free_total = free_total + (1 << o);
        if (free_total > COUNT_MAX) free_total = COUNT_MAX;
    endfunction

    function automatic void unlink_free(int unsigned o, int unsigned i);
        idx_t n;
        idx_t p;
        if (i >= NPAGES || o > TOP_ORD) return;
        n = page_nxt[i];
        p = page_prv[i];
        if (n != LINK_NIL && n < NPAGES) page_prv[n] = p;
        if (p != LINK_NIL && p < NPAGES) page_nxt[p] = n;
        else if (p == LINK_NIL) order_head[o] = n;
        page_nxt[i] = LINK_NIL;
        page_prv[i] = LINK_NIL;
        if (free_total >= (1 << o)) free_total = free_total - (1 << o);
    endfunction

    // Split a taken block down to the wanted order, returning right halves
    function automatic void split_block(int unsigned blk, int unsigned from, int unsigned want);
        int unsigned half;
        while (from > want)
        begin
            from--;
            half = blk + (1 << from);
            if (half < NPAGES)
            begin
                page_ord[half] = from[3:0];
                page_is_free[half] = 1'b1;
            end
            if (blk < NPAGES) page_ord[blk] = from[3:0];
            push_free(from, half);
        end
        if (blk < NPAGES)
        begin
            page_ord[blk] = want[3:0];
            page_is_free[blk] = 1'b0;
        end
    endfunction

    function automatic status_t release_block(int unsigned idx, int unsigned o);
        int unsigned lim;
        int unsigned cur;
        int unsigned bud;
        lim = page_bound();
        cur = idx;
        if (idx >= lim) return ST_RANGE;
        if (page_is_free[idx]) return ST_DOUBLE;
        if (page_ord[idx] != o) return ST_MISMATCH;
        // Merge with free buddies of equal order
        while (o < TOP_ORD)
        begin
            bud = cur ^ (1 << o);
            if (bud >= lim) break;
            if (!page_is_free[bud] || page_ord[bud] != o) break;
            unlink_free(o, bud);
            page_is_free[bud] = 1'b0;
            cur = cur & ~(1 << o);
            o++;
        end
        if (cur < NPAGES)
        begin
            page_is_free[cur] = 1'b1;
            page_ord[cur] = o[3:0];
        end
        push_free(o, cur);
        return ST_OK;
    endfunction

    // Carve a range into the largest self-aligned blocks
    function automatic void carve_range(int unsigned start, int unsigned stop);
        int unsigned lim;
        int unsigned i;
        int unsigned al;
        int unsigned sp;
        int unsigned o;
        int unsigned rest;
        lim = page_bound();
        i = start;
        if (stop > lim) stop = lim;
        while (i < stop)
        begin
            rest = stop - i;
            if (i == 0)
                al = TOP_ORD;
            else
            begin
                al = 0;
                while (((i >> al) & 1) == 0 && al < 31) al++;
            end
            sp = 0;
            while (sp < 31 && (rest >> (sp + 1)) != 0) sp++;
            o = (al < sp) ? al : sp;
            if (o > TOP_ORD) o = TOP_ORD;
            if (i < NPAGES)
            begin
                page_is_free[i] = 1'b1;
                page_ord[i] = o[3:0];
            end
            push_free(o, i);
            i = i + (1 << o);
        end
    endfunction

    function automatic void predict_request(ref page_req_t r);
        int unsigned f;
        int unsigned steps;
        int unsigned blk;
        idx_t        cur;
        bit          got;
        status_t     st;
        blk = 0;
        got = 0;
        st = ST_OK;
        if (r.mode == MODE_ALLOC || r.mode == MODE_ALLOC_LOW)
        begin
            st = ST_NO_BLOCK;
            for (f = r.ord; f <= TOP_ORD && !got; f++)
            begin
                cur = order_head[f];
                steps = 0;
                while (cur != LINK_NIL && steps < NPAGES)
                begin
                    if (r.mode == MODE_ALLOC || (int'(cur) + (1 << f)) <= cfg_low)
                    begin
                        unlink_free(f, cur);
                        split_block(cur, f, r.ord);
                        blk = cur;
                        st = ST_OK;
                        got = 1;
                        break;
                    end
                    if (r.mode == MODE_ALLOC) break;
                    cur = (cur < NPAGES) ? page_nxt[cur] : LINK_NIL;
                    steps++;
                end
            end
        end
        else if (r.mode == MODE_FREE)
            st = release_block(r.idx, r.ord);
        else
            carve_range(r.idx, r.end_idx);
        r.st = st;
        r.blk = (st == ST_OK) ? blk[15:0] : 16'd0;
        r.fp = free_total[16:0];
    endfunction

    // Predict one request, track owned blocks and queue it for the driver
    task automatic send_req(mode_t m, int unsigned o, int unsigned idx, int unsigned e);
        page_req_t r;
        r.mode = m;
        r.ord = o[3:0];
        r.idx = idx[15:0];
        r.end_idx = e[16:0];
        predict_request(r);
        if ((m == MODE_ALLOC || m == MODE_ALLOC_LOW) && r.st == ST_OK)
            held_blks.push_back('{idx: r.blk, ord: o});
        if (m == MODE_FREE && r.st == ST_OK)
        begin
            for (int k = 0; k < held_blks.size(); k++)
            begin
                if (held_blks[k].idx == idx)
                begin
                    held_blks.delete(k);
                    break;
                end
            end
        end
        pending_reqs.push_back(r);
        n_sent++;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic which, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= val[16:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (which == CFG_PAGE_COUNT) cfg_pages = val & 32'h1FFFF;
        else cfg_low = val & 32'h1FFFF;
    endtask

    task automatic gen_random_req();
        int unsigned pick;
        int unsigned k;
        int unsigned o;
        int unsigned len;
        int unsigned s;
        pick = $urandom_range(0, 99);
        if (pick >= 40 && pick < 75 && held_blks.size() != 0)
        begin
            // Free an owned block, now and then with the wrong order
            k = $urandom_range(0, held_blks.size() - 1);
            o = held_blks[k].ord;
            if ($urandom_range(0, 9) == 0) o = (o + $urandom_range(1, 15)) % 16;
            send_req(MODE_FREE, o, held_blks[k].idx, $urandom_range(0, 131071));
        end
        else if (pick >= 75 && pick < 85 && fresh_mark < FRESH_CAP)
        begin
            len = $urandom_range(1, 300);
            send_req(MODE_ADD, $urandom_range(0, 15), fresh_mark, fresh_mark + len);
            fresh_mark = fresh_mark + len;
        end
        else if (pick >= 85)
        begin
            // Noise: errors, empty or clamped ranges, odd orders
            s = $urandom_range(0, 65535);
            case ($urandom_range(0, 3))
                0: send_req(MODE_FREE, $urandom_range(11, 15), s, $urandom_range(0, 131071));
                1: send_req(MODE_FREE, $urandom_range(0, 15),
                            (page_bound() < NPAGES) ? $urandom_range(page_bound(), 65535)
                                                    : (s | 1), 0);
                2: send_req(MODE_ADD, $urandom_range(0, 15), s,
                            (s >= page_bound()) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, s));
                default: send_req(mode_t'($urandom_range(0, 1)), $urandom_range(0, 15), s,
                                  $urandom_range(0, 131071));
            endcase
        end
        else
        begin
            o = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            send_req(($urandom_range(0, 9) < 3) ? MODE_ALLOC_LOW : MODE_ALLOC, o, 0, 0);
        end
    endtask

    // Driver: present queued requests, hold while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) owed_results.push_back(in_flight);
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    in_flight = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    mode <= in_flight.mode;
                    block_order <= in_flight.ord;
                    page_index <= in_flight.idx;
                    end_index <= in_flight.end_idx;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stall, compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        page_req_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result status=%0d blk=%0d free=%0d",
                                 $realtime, status, block_index, avail_pages);
                end
                else
                begin
                    want = owed_results.pop_front();
                    n_checked++;
                    if (want.st <= ST_MISMATCH) n_status[want.st]++;
                    if (status !== want.st || block_index !== want.blk ||
                        avail_pages !== want.fp)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mode %0d ord %0d idx %0d end %0d: expected ",
                                      "st=%0d blk=%0d free=%0d, got st=%0d blk=%0d free=%0d"},
                                     $realtime, want.mode, want.ord, want.idx, want.end_idx,
                                     want.st, want.blk, want.fp,
                                     status, block_index, avail_pages);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Run limit
    initial
    begin
        #2_000_000_000;
        $display("Verification failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        int unsigned page_cfg [7];
        int unsigned low_cfg [7];
        int          phase_len [7];
        int          idle_mode;
        foreach (page_nxt[i])
        begin
            page_nxt[i] = LINK_NIL;
            page_prv[i] = LINK_NIL;
            page_ord[i] = '0;
            page_is_free[i] = 1'b0;
        end
        foreach (order_head[i]) order_head[i] = LINK_NIL;
        foreach (n_status[i]) n_status[i] = 0;
        free_total = 0;
        cfg_pages = CFG_RESET;
        cfg_low = CFG_RESET;
        fresh_mark = 2048;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(CFG_PAGE_COUNT, 65536);
        write_reg(CFG_LOW_LIMIT, 65536);

        // Directed: empty store, extremes, every mode and every status
        send_req(MODE_ALLOC, 0, 0, 0);
        send_req(MODE_ALLOC_LOW, 0, 0, 0);
        send_req(MODE_ADD, 0, 0, 2048);
        send_req(MODE_ADD, 15, 65000, 131071);
        send_req(MODE_ALLOC, 15, 0, 0);
        send_req(MODE_ALLOC, 10, 0, 0);
        send_req(MODE_ALLOC, 0, 0, 0);
        send_req(MODE_ALLOC_LOW, 3, 0, 0);
        send_req(MODE_FREE, 15, 0, 0);
        send_req(MODE_FREE, held_blks[1].ord, held_blks[1].idx, 0);
        send_req(MODE_FREE, 0, 65535, 0);
        send_req(MODE_ADD, 0, 100, 100);
        send_req(MODE_ADD, 0, 65535, 65536);
        send_req(MODE_ALLOC, 10, 0, 0);
        wait_drained();
        write_reg(CFG_PAGE_COUNT, 1000);
        write_reg(CFG_LOW_LIMIT, 1024);
        send_req(MODE_FREE, 0, 65535, 0);
        send_req(MODE_ALLOC_LOW, 0, 0, 0);
        send_req(MODE_ALLOC_LOW, 10, 0, 0);
        send_req(MODE_FREE, held_blks[0].ord, held_blks[0].idx, 0);
        wait_drained();

        // Random phases over a spread of settings and idling patterns
        page_cfg = '{4096, 65536, 1024, 131071, 0, 32768, 65536};
        low_cfg = '{4096, 65536, 512, 0, 1, 131071, 20000};
        phase_len = '{350, 400, 300, 80, 80, 400, 400};
        for (int p = 0; p < 7; p++)
        begin
            write_reg(CFG_PAGE_COUNT, page_cfg[p]);
            write_reg(CFG_LOW_LIMIT, low_cfg[p]);
            idle_mode = p % 4;
            gap_pct = (idle_mode == 1) ? 86 : (idle_mode == 3) ? 22 : 0;
            stall_pct = (idle_mode == 2) ? 86 : (idle_mode == 3) ? 22 : 0;
            for (int n = 0; n < phase_len[p]; n++)
            begin
                gen_random_req();
                // Let the block run dry once mid-phase
                if (n == phase_len[p] / 2) wait_drained();
                while (pending_reqs.size() > 16) @(posedge clk);
            end
            wait_drained();
        end

        gap_pct = 0;
        stall_pct = 0;
        repeat (300) @(posedge clk);
        $display("Sent %0d requests, checked %0d results, %0d mismatches", n_sent,
                 n_checked, mismatches);
        $display("Status mix: ok %0d, no block %0d, range %0d, double %0d, order %0d",
                 n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/bpa_pkg.sv
rtl/buddy_page_allocator_top.sv
tb/buddy_page_allocator_top_test.sv
